[rtl/core/acl_pkg.sv]
`default_nettype none

package acl_pkg;

  localparam int MAX_RULES_DEF = 16;
  localparam int ADDR_W        = 32;
  localparam int PLEN_W        = 6;
  localparam int CMD_W         = 2;
  localparam int STAT_W        = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_PLEN = 2'd2;

  localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_W);

  // one stored rule
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              deny;
  } entry_t;

  // query token walking down the cell row
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
    logic              found;
    logic              allow;
  } tok_t;

  // prefix length 0..32 to network mask, 0 gives an all-zero mask
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    return ~(ones >> plen);
  endfunction

endpackage

`default_nettype wire

[rtl/core/acl_cell.sv]
`default_nettype none

module acl_cell (
  input  wire              clk,
  input  wire              rst,
  input  wire              shift_en,
  input  wire              used,
  input  acl_pkg::entry_t  ent_in,
  output acl_pkg::entry_t  ent_out,
  input  acl_pkg::tok_t    tok_in,
  output acl_pkg::tok_t    tok_out
);

  acl_pkg::entry_t ent;
  acl_pkg::tok_t   tok;
  acl_pkg::tok_t   tok_next;

  // first hit wins; later cells hold older rules
  always_comb begin
    tok_next = tok_in;
    if (tok_in.vld && used && !tok_in.found &&
        ((tok_in.addr & ent.mask) == ent.addr)) begin
      tok_next.found = 1'b1;
      tok_next.allow = ~ent.deny;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent <= ent_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
  end

  assign ent_out = ent;
  assign tok_out = tok;

endmodule

`default_nettype wire

[rtl/core/ipv4_acl_first_match.sv]
`default_nettype none

// channel  direction  handshake           payload
// in       to block   in_valid/in_stall   cmd, rule_addr, prefix_len, deny_rule, query_addr
// out      from block out_valid/out_stall allowed, matched, status
//
// clear, add, unused commands, empty-table check: result in the cycle after the transfer
// check on a non-empty table: result once the token has walked
//   the row of MAX_RULES rule cells, one cell per cycle
// rst (synchronous) empties the table and drops any result in flight
// a waiting result that is stalled blocks new input transfers

module ipv4_acl_first_match #(
  parameter int MAX_RULES = acl_pkg::MAX_RULES_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [acl_pkg::CMD_W-1:0]    cmd,
  input  wire  [acl_pkg::ADDR_W-1:0]   rule_addr,
  input  wire  [acl_pkg::PLEN_W-1:0]   prefix_len,
  input  wire                          deny_rule,
  input  wire  [acl_pkg::ADDR_W-1:0]   query_addr,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         allowed,
  output logic                         matched,
  output logic [acl_pkg::STAT_W-1:0]   status
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic              in_xfer;
  logic              out_free;
  logic              bad_plen;
  logic              full;
  logic              shift_en;
  logic [MAX_RULES-1:0] used;

  acl_pkg::entry_t   new_ent;
  acl_pkg::tok_t     tok_head;
  acl_pkg::entry_t   ent_chain [MAX_RULES];
  acl_pkg::tok_t     tok_chain [MAX_RULES];
  acl_pkg::tok_t     tok_last;

  // output slot is free if empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state == S_WALK) || !out_free;
  assign in_xfer  = in_valid && !in_stall;

  assign bad_plen = prefix_len > acl_pkg::PLEN_MAX;
  assign full     = count == CNT_W'(MAX_RULES);

  // add pushes the new rule into cell 0 and every rule one cell down
  assign shift_en = in_xfer && (cmd == acl_pkg::CMD_ADD) && !bad_plen && !full;

  always_comb begin
    new_ent.mask = acl_pkg::prefix_mask(prefix_len);
    new_ent.addr = rule_addr & new_ent.mask;
    new_ent.deny = deny_rule;
  end

  // a check on a non-empty table injects a token at cell 0
  always_comb begin
    tok_head.vld   = in_xfer && (cmd == acl_pkg::CMD_CHECK) && (count != '0);
    tok_head.addr  = query_addr;
    tok_head.found = 1'b0;
    tok_head.allow = 1'b0;
  end

  // cell 0 holds the newest rule, cells at count and beyond are empty
  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    assign used[i] = CNT_W'(i) < count;

    if (i == 0) begin : g_first
      acl_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (shift_en),
        .used     (used[i]),
        .ent_in   (new_ent),
        .ent_out  (ent_chain[i]),
        .tok_in   (tok_head),
        .tok_out  (tok_chain[i])
      );
    end else begin : g_rest
      acl_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (shift_en),
        .used     (used[i]),
        .ent_in   (ent_chain[i-1]),
        .ent_out  (ent_chain[i]),
        .tok_in   (tok_chain[i-1]),
        .tok_out  (tok_chain[i])
      );
    end
  end

  assign tok_last = tok_chain[MAX_RULES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      allowed   <= 1'b0;
      matched   <= 1'b0;
      status    <= acl_pkg::STAT_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            // a check on a non-empty table answers only after the walk
            out_valid <= !((cmd == acl_pkg::CMD_CHECK) && (count != '0));
            // empty table lets everything through
            allowed   <= (cmd == acl_pkg::CMD_CHECK) && (count == '0);
            matched   <= 1'b0;
            case (cmd)
              acl_pkg::CMD_CLEAR: begin
                status <= acl_pkg::STAT_OK;
                count  <= '0;
              end
              acl_pkg::CMD_ADD: begin
                if (bad_plen) begin
                  status <= acl_pkg::STAT_BAD_PLEN;
                end else if (full) begin
                  status <= acl_pkg::STAT_FULL;
                end else begin
                  status <= acl_pkg::STAT_OK;
                  count  <= count + CNT_W'(1);
                end
              end
              acl_pkg::CMD_CHECK: begin
                status <= acl_pkg::STAT_OK;
                if (count != '0) begin
                  state <= S_WALK;
                end
              end
              default: begin
                status <= acl_pkg::STAT_OK;
              end
            endcase
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        S_WALK: begin
          // token leaves the last cell; no match means deny
          // out_valid stays low for the whole walk
          if (tok_last.vld) begin
            out_valid <= 1'b1;
            allowed   <= tok_last.found & tok_last.allow;
            matched   <= tok_last.found;
            status    <= acl_pkg::STAT_OK;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/acl_chk.sv]
`default_nettype none

module acl_chk (
  input wire                        clk,
  input wire                        rst,
  input wire                        in_valid,
  input wire                        in_stall,
  input wire [acl_pkg::CMD_W-1:0]   cmd,
  input wire [acl_pkg::PLEN_W-1:0]  prefix_len,
  input wire                        out_valid,
  input wire                        out_stall,
  input wire                        allowed,
  input wire                        matched,
  input wire [acl_pkg::STAT_W-1:0]  status
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // clear answers next cycle with an all-zero result
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (cmd == acl_pkg::CMD_CLEAR) |=>
      out_valid && !allowed && !matched && (status == acl_pkg::STAT_OK))
    else $error("clear result wrong");

  // a bad prefix always reports its own status, ahead of table full
  a_bad_prefix: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (cmd == acl_pkg::CMD_ADD) && (prefix_len > acl_pkg::PLEN_MAX) |=>
      out_valid && (status == acl_pkg::STAT_BAD_PLEN))
    else $error("bad prefix not flagged");

  // an add failure never carries a verdict
  a_fail_no_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != acl_pkg::STAT_OK) |-> !allowed && !matched)
    else $error("failed add carries a verdict");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == acl_pkg::STAT_OK) || (status == acl_pkg::STAT_FULL) ||
                  (status == acl_pkg::STAT_BAD_PLEN))
    else $error("unknown status code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(allowed) && $stable(matched) && $stable(status))
    else $error("stalled result changed");

endmodule

bind ipv4_acl_first_match acl_chk u_acl_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .cmd        (cmd),
  .prefix_len (prefix_len),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .allowed    (allowed),
  .matched    (matched),
  .status     (status)
);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

// one result transfer as the block reports it
typedef struct packed {
  logic                      allowed;
  logic                      matched;
  logic [acl_pkg::STAT_W-1:0] status;
} verdict_t;

class acl_scoreboard;
  localparam int DEPTH = acl_pkg::MAX_RULES_DEF;

  logic [acl_pkg::ADDR_W-1:0] rule_net  [DEPTH];
  logic [acl_pkg::ADDR_W-1:0] rule_mask [DEPTH];
  logic                       rule_deny [DEPTH];
  int                         rule_total;

  verdict_t    verdict_q[$];
  int unsigned failures, checks, hits, full_drops, plen_drops, clears;

  function new();
    rule_total = 0;
    failures   = 0;
    checks     = 0;
    hits       = 0;
    full_drops = 0;
    plen_drops = 0;
    clears     = 0;
  endfunction

  function int unsigned pending();
    return verdict_q.size();
  endfunction

  // update the table copy and queue the verdict for one accepted command
  function void note_command(input logic [acl_pkg::CMD_W-1:0]  op,
                             input logic [acl_pkg::ADDR_W-1:0] raddr,
                             input logic [acl_pkg::PLEN_W-1:0] plen,
                             input logic                       deny,
                             input logic [acl_pkg::ADDR_W-1:0] qaddr);
    verdict_t                   v;
    logic [acl_pkg::ADDR_W-1:0] m;
    int                         sh;
    v.allowed = 1'b0;
    v.matched = 1'b0;
    v.status  = acl_pkg::STAT_OK;
    case (op)
      acl_pkg::CMD_CLEAR: begin
        rule_total = 0;
        clears++;
      end
      acl_pkg::CMD_ADD: begin
        if (plen > acl_pkg::PLEN_MAX) begin
          v.status = acl_pkg::STAT_BAD_PLEN;
          plen_drops++;
        end else if (rule_total >= DEPTH) begin
          v.status = acl_pkg::STAT_FULL;
          full_drops++;
        end else begin
          sh = acl_pkg::ADDR_W - int'(plen);
          m  = (plen == 0) ? '0 : ({acl_pkg::ADDR_W{1'b1}} << sh);
          rule_net[rule_total]  = raddr & m;
          rule_mask[rule_total] = m;
          rule_deny[rule_total] = deny;
          rule_total++;
        end
      end
      acl_pkg::CMD_CHECK: begin
        checks++;
        if (rule_total == 0) begin
          v.allowed = 1'b1;
        end else begin
          for (int i = rule_total - 1; i >= 0; i--) begin
            if ((qaddr & rule_mask[i]) == rule_net[i]) begin
              v.matched = 1'b1;
              v.allowed = ~rule_deny[i];
              break;
            end
          end
        end
        if (v.matched) hits++;
      end
      default: ;
    endcase
    verdict_q.push_back(v);
  endfunction

  function void check_result(input logic                       allowed,
                             input logic                       matched,
                             input logic [acl_pkg::STAT_W-1:0] status);
    verdict_t want;
    if (verdict_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: result with nothing pending: allowed %0b matched %0b status %0d",
                 $realtime, allowed, matched, status);
      return;
    end
    want = verdict_q.pop_front();
    if (allowed !== want.allowed || matched !== want.matched || status !== want.status) begin
      failures++;
      if (failures <= 10)
        $display("%0t: mismatch: expected allowed %0b matched %0b status %0d, got %0b %0b %0d",
                 $realtime, want.allowed, want.matched, want.status, allowed, matched, status);
    end
  endfunction
endclass

module testbench;

  // the fourth command code has no name in the package
  localparam logic [acl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 800;
  localparam int HOLD_START    = 600;   // receiver cycle at which the long hold-off begins
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_CYCLES  = 40;    // a check walks the whole row of MAX_RULES cells

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  wire                        in_stall;
  logic [acl_pkg::CMD_W-1:0]  cmd;
  logic [acl_pkg::ADDR_W-1:0] rule_addr;
  logic [acl_pkg::PLEN_W-1:0] prefix_len;
  logic                       deny_rule;
  logic [acl_pkg::ADDR_W-1:0] query_addr;
  wire                        out_valid;
  logic                       out_stall;
  wire                        allowed;
  wire                        matched;
  wire [acl_pkg::STAT_W-1:0]  status;

  acl_scoreboard sb;
  int unsigned   sent;        // accepted input transfers, ignored commands excluded
  int unsigned   burst_left;

  ipv4_acl_first_match uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .rule_addr  (rule_addr),
    .prefix_len (prefix_len),
    .deny_rule  (deny_rule),
    .query_addr (query_addr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .allowed    (allowed),
    .matched    (matched),
    .status     (status)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // overall time limit, several times the slowest legal run
  initial begin
    #5000000;
    $display("FAIL ipv4_acl_first_match");
    $finish;
  end

  // result side: every accepted transfer goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(allowed, matched, status);
  end

  // receiver stall pattern: free-running stretches, light and heavy random stalls,
  // a periodic pattern, and one long hold-off so a result waits and input stalls
  initial begin
    int unsigned cyc, span, mode;
    logic        hold;
    cyc = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        cyc++;
        case (mode)
          0:       hold = 1'b0;
          1:       hold = ($urandom_range(0, 99) < 30);
          2:       hold = ($urandom_range(0, 99) < 75);
          default: hold = k[1];
        endcase
        if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) hold = 1'b1;
        out_stall <= hold;
      end
    end
  end

  // sender pacing: bursts of random length, random gaps in between
  task automatic pace();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  // offer one command and hold it until the transfer
  task automatic offer(input logic [acl_pkg::CMD_W-1:0]  op,
                       input logic [acl_pkg::ADDR_W-1:0] raddr,
                       input logic [acl_pkg::PLEN_W-1:0] plen,
                       input logic                       deny,
                       input logic [acl_pkg::ADDR_W-1:0] qaddr);
    cmd        <= op;
    rule_addr  <= raddr;
    prefix_len <= plen;
    deny_rule  <= deny;
    query_addr <= qaddr;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_command(op, raddr, plen, deny, qaddr);
    if (op != CMD_UNUSED) sent++;
    pace();
  endtask

  // fields a command ignores still carry random values
  task automatic add_rule(input logic [acl_pkg::ADDR_W-1:0] raddr,
                          input logic [acl_pkg::PLEN_W-1:0] plen,
                          input logic deny);
    offer(acl_pkg::CMD_ADD, raddr, plen, deny, $urandom);
  endtask

  task automatic check_addr(input logic [acl_pkg::ADDR_W-1:0] qaddr);
    offer(acl_pkg::CMD_CHECK, $urandom, acl_pkg::PLEN_W'($urandom_range(0, 63)),
          1'($urandom_range(0, 1)), qaddr);
  endtask

  task automatic clear_table();
    offer(acl_pkg::CMD_CLEAR, $urandom, acl_pkg::PLEN_W'($urandom_range(0, 63)),
          1'($urandom_range(0, 1)), $urandom);
  endtask

  task automatic unused_cmd();
    offer(CMD_UNUSED, $urandom, acl_pkg::PLEN_W'($urandom_range(0, 63)),
          1'($urandom_range(0, 1)), $urandom);
  endtask

  // mostly /1../31 rules, some host routes, rare catch-alls and bad prefixes
  task automatic random_add();
    int unsigned                r;
    logic [acl_pkg::PLEN_W-1:0] plen;
    r = $urandom_range(0, 99);
    if (r < 5)       plen = '0;
    else if (r < 12) plen = acl_pkg::PLEN_W'($urandom_range(33, 63));
    else if (r < 20) plen = acl_pkg::PLEN_MAX;
    else             plen = acl_pkg::PLEN_W'($urandom_range(1, 31));
    add_rule($urandom, plen, 1'($urandom_range(0, 1)));
  endtask

  // aim most queries at a stored rule, some one bit off its network, the rest anywhere
  function automatic logic [acl_pkg::ADDR_W-1:0] pick_query();
    int unsigned                r, idx;
    logic [acl_pkg::ADDR_W-1:0] q, m;
    r = $urandom_range(0, 9);
    if (sb.rule_total == 0 || r >= 7) return $urandom;
    idx = $urandom_range(0, sb.rule_total - 1);
    m   = sb.rule_mask[idx];
    q   = sb.rule_net[idx] | ($urandom & ~m);
    if (r >= 5) q = q ^ (m & (~m + 1));   // flip the lowest network bit
    return q;
  endfunction

  initial begin
    int unsigned n;
    sb         = new();
    sent       = 0;
    burst_left = 0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    cmd        <= acl_pkg::CMD_CLEAR;
    rule_addr  <= '0;
    prefix_len <= '0;
    deny_rule  <= 1'b0;
    query_addr <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, unused command, bad prefixes, host route,
    // miss, catch-all, fill to full, bad prefix on a full table, clear
    check_addr(32'h0A00_0001);
    offer(CMD_UNUSED, '1, '1, 1'b1, '1);
    add_rule(32'h0A0B_0C0D, 6'd33, 1'b0);
    add_rule('1, 6'd63, 1'b1);
    add_rule('1, acl_pkg::PLEN_MAX, 1'b1);
    check_addr('1);
    check_addr('0);
    add_rule(32'hC0A8_1234, 6'd16, 1'b0);
    check_addr(32'hC0A8_FFFF);
    add_rule($urandom, '0, 1'b0);
    check_addr('0);
    for (int i = 1; i <= 13; i++) add_rule($urandom, acl_pkg::PLEN_W'(i * 2 + 1), i[0]);
    add_rule($urandom, 6'd8, 1'b0);
    add_rule($urandom, 6'd40, 1'b1);
    check_addr('1);
    clear_table();
    check_addr($urandom);
    n = sent;

    // random: table-building episodes with checks in between, some without a clear
    // first so adds also land on a full table
    while (sent < n + RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) clear_table();
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(0, 24) == 0) unused_cmd();
        random_add();
        repeat ($urandom_range(0, 2)) check_addr(pick_query());
      end
      repeat ($urandom_range(2, 10)) check_addr(pick_query());
    end
    in_valid <= 1'b0;

    // drain, then give stray results time to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transfers: %0d checks (%0d hit a rule), %0d clears",
             sent, sb.checks, sb.hits, sb.clears);
    $display("adds dropped: %0d on a full table, %0d on a bad prefix; %0d failures",
             sb.full_drops, sb.plen_drops, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS ipv4_acl_first_match");
    end else begin
      $display("FAIL ipv4_acl_first_match");
    end
    $finish;
  end

endmodule
